@@ rtl/chc_pkg.sv @@
// Shared types, constants and the arctangent table of the compass heading core.
package chc_pkg;

	localparam int SMP_W      = 16;
	localparam int DIFF_W     = SMP_W + 1;
	localparam int DECL_W     = 9;
	localparam int HEAD_W     = 10;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int XY_W       = 20;
	localparam int ANG_W      = 26;
	localparam int DEG_W      = 9;
	localparam int SUM_W      = 11;
	localparam int TAB_AW     = 5;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SPAN_THRESHOLD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DECLINATION    = 1'd1;

	localparam logic KIND_HEADING = 1'b0;
	localparam logic KIND_REPORT  = 1'b1;

	localparam logic signed [ANG_W-1:0] ANG_0   = ANG_W'(0);
	localparam logic signed [ANG_W-1:0] ANG_90  = ANG_W'(90 * 65536);
	localparam logic signed [ANG_W-1:0] ANG_180 = ANG_W'(180 * 65536);
	localparam logic signed [ANG_W-1:0] ANG_270 = ANG_W'(270 * 65536);
	localparam logic signed [ANG_W-1:0] ANG_360 = ANG_W'(360 * 65536);
	localparam logic signed [SUM_W-1:0] DEG_360 = SUM_W'(360);

	typedef struct packed {
		logic signed [SMP_W-1:0] x;
		logic signed [SMP_W-1:0] y;
		logic signed [SMP_W-1:0] z;
	} offs_t;

	typedef struct packed {
		logic                     kind;
		logic signed [DIFF_W-1:0] dx;
		logic signed [DIFF_W-1:0] dy;
	} job_t;

	// round(atan(2^-i) in degrees * 65536)
	function automatic logic [ANG_W-2:0] atan_tab(input logic [TAB_AW-1:0] idx);
		logic [ANG_W-2:0] v;
		unique case (idx)
			5'd0:  v = 25'd2949120;
			5'd1:  v = 25'd1740967;
			5'd2:  v = 25'd919879;
			5'd3:  v = 25'd466945;
			5'd4:  v = 25'd234379;
			5'd5:  v = 25'd117304;
			5'd6:  v = 25'd58666;
			5'd7:  v = 25'd29335;
			5'd8:  v = 25'd14668;
			5'd9:  v = 25'd7334;
			5'd10: v = 25'd3667;
			5'd11: v = 25'd1833;
			5'd12: v = 25'd917;
			5'd13: v = 25'd458;
			5'd14: v = 25'd229;
			5'd15: v = 25'd115;
			5'd16: v = 25'd57;
			5'd17: v = 25'd29;
			5'd18: v = 25'd14;
			5'd19: v = 25'd7;
			5'd20: v = 25'd4;
			5'd21: v = 25'd2;
			5'd22: v = 25'd1;
			default: v = 25'd0;
		endcase
		return v;
	endfunction

endpackage

@@ rtl/chc_ifs.sv @@
// Valid/ready channel interfaces for magnetometer samples and results.
interface chc_sample_if
	import chc_pkg::*;
;
	logic                    valid;
	logic                    ready;
	logic signed [SMP_W-1:0] mag_x;
	logic signed [SMP_W-1:0] mag_y;
	logic signed [SMP_W-1:0] mag_z;

	modport source (output valid, output mag_x, output mag_y, output mag_z, input ready);
	modport sink   (input valid, input mag_x, input mag_y, input mag_z, output ready);
endinterface

interface chc_result_if
	import chc_pkg::*;
;
	logic                     valid;
	logic                     ready;
	logic                     result_kind;
	logic signed [HEAD_W-1:0] heading_deg;
	logic signed [SMP_W-1:0]  offset_x_out;
	logic signed [SMP_W-1:0]  offset_y_out;
	logic signed [SMP_W-1:0]  offset_z_out;

	modport source (output valid, output result_kind, output heading_deg,
		output offset_x_out, output offset_y_out, output offset_z_out, input ready);
	modport sink   (input valid, input result_kind, input heading_deg,
		input offset_x_out, input offset_y_out, input offset_z_out, output ready);
endinterface

@@ rtl/chc_queue.sv @@
// Small flop-based job queue between the sample front end and the CORDIC back end.
module chc_queue
	import chc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_data,
	output logic full,
	input  logic pop,
	output job_t pop_data,
	output logic empty
);

	localparam int AW = $clog2(QUEUE_DEPTH);

	job_t          mem_q [QUEUE_DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   cnt_q;

	assign full     = (cnt_q == (AW+1)'(QUEUE_DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (pop && !empty) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			unique case ({push && !full, pop && !empty})
				2'b10:   cnt_q <= cnt_q + (AW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (AW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(QUEUE_DEPTH))
		else $error("job queue holds more entries than its depth");

endmodule

@@ rtl/chc_front.sv @@
// Front end: accepts samples, tracks calibration extremes, sets offsets and queues jobs.
module chc_front
	import chc_pkg::*;
#(
	parameter int CAL_SAMPLES = 11
) (
	input  logic                  clk,
	input  logic                  arst_n,
	chc_sample_if.sink            sample,
	input  logic [SMP_W-1:0]      span_threshold,
	output offs_t                 offs,
	output logic                  q_push,
	output job_t                  q_data,
	input  logic                  q_full
);

	localparam int CNT_W = $clog2(CAL_SAMPLES);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CAL_SAMPLES - 1);

	typedef enum logic [1:0] {
		FS_RUN = 2'b01,
		FS_FIN = 2'b10
	} front_state_t;

	front_state_t            state_q;
	logic                    calibrated_q;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [SMP_W-1:0] max_q [3];
	logic signed [SMP_W-1:0] min_q [3];
	offs_t                   offs_q;

	logic signed [SMP_W-1:0] smp [3];
	logic signed [SMP_W-1:0] new_off [3];
	logic                    take;

	assign smp[0] = sample.mag_x;
	assign smp[1] = sample.mag_y;
	assign smp[2] = sample.mag_z;

	assign sample.ready = (state_q == FS_RUN) && !q_full;
	assign take         = sample.valid && sample.ready;
	assign offs         = offs_q;

	// Offset of an axis: midpoint of its range, truncated toward zero, when
	// the span clears the threshold.
	always_comb begin
		logic signed [DIFF_W-1:0] span;
		logic signed [DIFF_W-1:0] sum;
		logic signed [DIFF_W-1:0] adj;
		for (int a = 0; a < 3; a++) begin
			span = {max_q[a][SMP_W-1], max_q[a]} - {min_q[a][SMP_W-1], min_q[a]};
			sum  = {max_q[a][SMP_W-1], max_q[a]} + {min_q[a][SMP_W-1], min_q[a]};
			adj  = sum + DIFF_W'(sum[DIFF_W-1]);
			new_off[a] = ($unsigned(span) > {1'b0, span_threshold}) ?
				adj[DIFF_W-1:1] : '0;
		end
	end

	always_comb begin
		q_push     = 1'b0;
		q_data     = '0;
		q_data.dx  = {sample.mag_x[SMP_W-1], sample.mag_x} - {offs_q.x[SMP_W-1], offs_q.x};
		q_data.dy  = {sample.mag_y[SMP_W-1], sample.mag_y} - {offs_q.y[SMP_W-1], offs_q.y};
		if (state_q == FS_FIN) begin
			q_push      = !q_full;
			q_data.kind = KIND_REPORT;
			q_data.dx   = '0;
			q_data.dy   = '0;
		end else if (take && calibrated_q) begin
			q_push      = 1'b1;
			q_data.kind = KIND_HEADING;
		end
	end

	always_ff @(posedge clk) begin
		if (take && !calibrated_q) begin
			for (int a = 0; a < 3; a++) begin
				if (cnt_q == '0 || smp[a] > max_q[a]) begin
					max_q[a] <= smp[a];
				end
				if (cnt_q == '0 || smp[a] < min_q[a]) begin
					min_q[a] <= smp[a];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= FS_RUN;
			calibrated_q <= 1'b0;
			cnt_q        <= '0;
			offs_q       <= '0;
		end else begin
			unique case (state_q)
				FS_RUN: begin
					if (take && !calibrated_q) begin
						if (cnt_q == CNT_LAST) begin
							state_q <= FS_FIN;
						end else begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
				end
				FS_FIN: begin
					if (!q_full) begin
						offs_q.x     <= new_off[0];
						offs_q.y     <= new_off[1];
						offs_q.z     <= new_off[2];
						calibrated_q <= 1'b1;
						state_q      <= FS_RUN;
					end
				end
				default: state_q <= FS_RUN;
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!calibrated_q |-> cnt_q <= CNT_LAST)
		else $error("calibration count ran past the last calibration sample");

endmodule

@@ rtl/chc_back.sv @@
// Back end: iterative CORDIC angle, degree conversion, declination and result register.
module chc_back
	import chc_pkg::*;
#(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_empty,
	input  job_t                     q_data,
	output logic                     q_pop,
	input  offs_t                    offs,
	input  logic signed [DECL_W-1:0] declination_deg,
	chc_result_if.source             result
);

	localparam int STEP_W = $clog2(CORDIC_STEPS);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);

	typedef enum logic [3:0] {
		BS_IDLE = 4'b0001,
		BS_ITER = 4'b0010,
		BS_WRAP = 4'b0100,
		BS_OUT  = 4'b1000
	} back_state_t;

	back_state_t              state_q;
	logic [STEP_W-1:0]        step_q;
	logic                     kind_q;
	logic signed [XY_W-1:0]   x_q;
	logic signed [XY_W-1:0]   y_q;
	logic signed [ANG_W-1:0]  z_q;

	logic                     out_valid_q;
	logic                     out_kind_q;
	logic signed [HEAD_W-1:0] out_head_q;
	offs_t                    out_offs_q;

	logic signed [XY_W-1:0]   x0;
	logic signed [XY_W-1:0]   y0;
	logic signed [XY_W-1:0]   xs;
	logic signed [XY_W-1:0]   ys;
	logic signed [ANG_W-1:0]  atan_val;
	logic signed [SUM_W-1:0]  hsum;
	logic signed [SUM_W-1:0]  hfin;
	logic                     out_free;

	assign x0 = {{(XY_W-DIFF_W){q_data.dx[DIFF_W-1]}}, q_data.dx};
	assign y0 = {{(XY_W-DIFF_W){q_data.dy[DIFF_W-1]}}, q_data.dy};
	assign xs = x_q >>> step_q;
	assign ys = y_q >>> step_q;
	assign atan_val = {1'b0, atan_tab(TAB_AW'(step_q))};

	// Whole degrees of the wrapped angle plus declination, folded once.
	assign hsum = {2'b00, z_q[ANG_W-2 -: DEG_W]} +
		{{(SUM_W-DECL_W){declination_deg[DECL_W-1]}}, declination_deg};
	assign hfin = (hsum > DEG_360) ? (hsum - DEG_360) : hsum;

	assign out_free = !out_valid_q || result.ready;
	assign q_pop    = (state_q == BS_IDLE) && !q_empty;

	assign result.valid        = out_valid_q;
	assign result.result_kind  = out_kind_q;
	assign result.heading_deg  = out_head_q;
	assign result.offset_x_out = out_offs_q.x;
	assign result.offset_y_out = out_offs_q.y;
	assign result.offset_z_out = out_offs_q.z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BS_IDLE;
			step_q      <= '0;
			kind_q      <= KIND_HEADING;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == BS_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				BS_IDLE: begin
					if (!q_empty) begin
						kind_q <= q_data.kind;
						step_q <= '0;
						if (q_data.kind == KIND_REPORT) begin
							state_q <= BS_OUT;
						end else if (q_data.dy == '0 || q_data.dx == '0) begin
							state_q <= BS_WRAP;
						end else begin
							state_q <= BS_ITER;
						end
					end
				end
				BS_ITER: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_LAST) begin
						state_q <= BS_WRAP;
					end
				end
				BS_WRAP: state_q <= BS_OUT;
				BS_OUT: begin
					if (out_free) begin
						state_q <= BS_IDLE;
					end
				end
				default: state_q <= BS_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			BS_IDLE: begin
				if (!q_empty) begin
					// Axis cases resolve exactly; a vector left of the Y axis is
					// turned by half a circle before rotating.
					if (q_data.dy == '0) begin
						z_q <= q_data.dx[DIFF_W-1] ? ANG_180 : ANG_0;
					end else if (q_data.dx == '0) begin
						z_q <= q_data.dy[DIFF_W-1] ? ANG_270 : ANG_90;
					end else if (q_data.dx[DIFF_W-1]) begin
						x_q <= -x0;
						y_q <= -y0;
						z_q <= ANG_180;
					end else begin
						x_q <= x0;
						y_q <= y0;
						z_q <= ANG_0;
					end
				end
			end
			BS_ITER: begin
				if (!y_q[XY_W-1]) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + atan_val;
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - atan_val;
				end
			end
			BS_WRAP: begin
				if (z_q[ANG_W-1]) begin
					z_q <= z_q + ANG_360;
				end
			end
			BS_OUT: begin
				if (out_free) begin
					out_kind_q <= kind_q;
					out_head_q <= (kind_q == KIND_REPORT) ? '0 : hfin[HEAD_W-1:0];
					out_offs_q <= offs;
				end
			end
			default: ;
		endcase
	end

	a_angle_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BS_OUT && kind_q == KIND_HEADING) |-> !z_q[ANG_W-1])
		else $error("wrapped angle is negative");

	a_angle_below_turn: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BS_OUT && kind_q == KIND_HEADING) |-> z_q < ANG_360)
		else $error("wrapped angle reaches a full turn");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result.ready) |=> (out_valid_q && $stable(out_head_q)
			&& $stable(out_kind_q)))
		else $error("result register changed while the result waited");

endmodule

@@ rtl/compass_heading_hard_iron_cal_core.sv @@
// Top level of the hard-iron calibrated compass heading core.
// Calibration samples transfer one per cycle; after the last, the sample input closes while offsets are set.
// A heading sample passes the job queue and the back-end states up to BS_OUT on its way to the result register.
// Heading jobs share the single CORDIC rotator, which takes a new job only after the last has left BS_OUT.
// The two-entry job queue lets samples transfer while an earlier result still waits.
// Reset clears the calibration count, offsets, registers, queue and result valid; min/max do not reset.
module compass_heading_hard_iron_cal_core
	import chc_pkg::*;
#(
	parameter int CAL_SAMPLES  = 11,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	chc_sample_if.sink            sample,
	chc_result_if.source          result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Configuration registers. Writes are to happen only while the core is idle, a rule for the user
	// that the core itself does not enforce; both halves read them directly.
	logic [SMP_W-1:0]         span_threshold_q;
	logic signed [DECL_W-1:0] declination_q;

	// Offsets live in the front end; the back end copies them into each result.
	offs_t offs;

	// Job queue handshake between the two halves.
	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;
	job_t q_wdata;
	job_t q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_threshold_q <= '0;
			declination_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SPAN_THRESHOLD: span_threshold_q <= cfg_data[SMP_W-1:0];
				REG_DECLINATION:    declination_q    <= cfg_data[DECL_W-1:0];
				default: ;
			endcase
		end
	end

	// The front end classifies each sample: calibration samples update the
	// extremes, the last one queues a report, and later samples queue a
	// heading job with the offsets already removed.
	chc_front #(
		.CAL_SAMPLES (CAL_SAMPLES)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample         (sample),
		.span_threshold (span_threshold_q),
		.offs           (offs),
		.q_push         (q_push),
		.q_data         (q_wdata),
		.q_full         (q_full)
	);

	chc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.empty     (q_empty)
	);

	// The back end runs the vectoring CORDIC one micro-rotation per cycle and
	// holds the finished result in an output register until its transfer.
	chc_back #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_empty         (q_empty),
		.q_data          (q_rdata),
		.q_pop           (q_pop),
		.offs            (offs),
		.declination_deg (declination_q),
		.result          (result)
	);

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the hard-iron calibrated compass heading core.
module testbench
	import chc_pkg::*;
;

	// Calibration length and rotator depth match the core's defaults.
	localparam int CAL_SAMPLES  = 11;
	localparam int CORDIC_ITERS = 16;

	// Angles inside the predictor are kept in 1/65536 degree.
	localparam longint DEG_UNIT = 65536;

	// A settling wait is allowed before a register write and at the end of the run, so that
	// the core can finish anything that produces no result.
	localparam int SETTLE_CYCLES = 2 * (CORDIC_ITERS + 3);

	// Hard stop for a hung core, well above the slowest legal run.
	localparam int CYCLE_LIMIT = 1000000;

	// Random headings per phase. Six phases follow the directed table.
	localparam int PHASE_ITEMS = 321;

	// Offsets that the directed calibration samples below must produce.
	// X: min -32768, max 30001, so (-2767)/2 truncates to -1383.
	// Y: min -100, max 32767, so 32667/2 truncates to 16333.
	// Z: span of 500 stays under the threshold, so no offset is applied.
	localparam logic signed [SMP_W-1:0] CAL_OFS_X = -16'sd1383;
	localparam logic signed [SMP_W-1:0] CAL_OFS_Y = 16'sd16333;
	localparam logic signed [SMP_W-1:0] CAL_OFS_Z = 16'sd0;

	// Rotation angles for each CORDIC iteration, atan(2^-i) in 1/65536 degree.
	localparam int ATAN_STEP [16] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115
	};

	// One result as the core presents it on the result channel.
	typedef struct packed {
		logic                     kind;
		logic signed [HEAD_W-1:0] hdg;
		logic signed [SMP_W-1:0]  ofs_x;
		logic signed [SMP_W-1:0]  ofs_y;
		logic signed [SMP_W-1:0]  ofs_z;
	} reading_t;

	// One row of the directed table. When wr is set, the core is drained and the
	// register is written before the sample goes out. When typed is set, the
	// heading in the row is the expected value and the offsets are the ones that
	// the directed calibration produces. Otherwise the predictor supplies the result.
	typedef struct packed {
		logic                     wr;
		logic [CFG_IDX_W-1:0]     reg_idx;
		logic [CFG_DATA_W-1:0]    reg_val;
		logic signed [SMP_W-1:0]  x;
		logic signed [SMP_W-1:0]  y;
		logic signed [SMP_W-1:0]  z;
		logic                     typed;
		logic signed [HEAD_W-1:0] hdg;
	} dir_row_t;

	localparam int DIR_ROWS = 24;

	dir_row_t dir_table [DIR_ROWS] = '{
		// Calibration. The first sample seeds min and max. The threshold is
		// lowered in the middle, and the value in force at the last sample counts.
		'{1'b0, REG_SPAN_THRESHOLD, 16'd0,     16'sd0,      16'sd0,     16'sd100,  1'b0, 10'sd0},
		'{1'b0, REG_SPAN_THRESHOLD, 16'd0,    -16'sd32768, -16'sd100,   16'sd200,  1'b0, 10'sd0},
		'{1'b0, REG_SPAN_THRESHOLD, 16'd0,     16'sd30001,  16'sd32767, 16'sd150,  1'b0, 10'sd0},
		'{1'b0, REG_SPAN_THRESHOLD, 16'd0,     16'sd100,    16'sd6000, -16'sd200,  1'b0, 10'sd0},
		'{1'b0, REG_SPAN_THRESHOLD, 16'd0,    -16'sd5000,   16'sd20000, 16'sd300,  1'b0, 10'sd0},
		'{1'b1, REG_SPAN_THRESHOLD, 16'd1000,  16'sd12345, -16'sd50,    16'sd0,    1'b0, 10'sd0},
		'{1'b0, REG_SPAN_THRESHOLD, 16'd0,    -16'sd20000,  16'sd100,   16'sd50,   1'b0, 10'sd0},
		'{1'b0, REG_SPAN_THRESHOLD, 16'd0,     16'sd29999,  16'sd32000,-16'sd100,  1'b0, 10'sd0},
		'{1'b0, REG_SPAN_THRESHOLD, 16'd0,    -16'sd32767, -16'sd99,    16'sd250,  1'b0, 10'sd0},
		'{1'b0, REG_SPAN_THRESHOLD, 16'd0,     16'sd7,      16'sd1234, -16'sd150,  1'b0, 10'sd0},
		// The last calibration sample, which gives the report.
		'{1'b0, REG_SPAN_THRESHOLD, 16'd0,    -16'sd1,      16'sd30000, 16'sd10,   1'b0, 10'sd0},
		// Headings with no declination. The zero vector and the four axes.
		'{1'b0, REG_SPAN_THRESHOLD, 16'd0,    -16'sd1383,   16'sd16333,-16'sd32768,1'b1, 10'sd0},
		'{1'b0, REG_SPAN_THRESHOLD, 16'd0,     16'sd30000,  16'sd16333, 16'sd32767,1'b1, 10'sd0},
		'{1'b0, REG_SPAN_THRESHOLD, 16'd0,    -16'sd32768,  16'sd16333, 16'sd0,    1'b1, 10'sd180},
		'{1'b0, REG_SPAN_THRESHOLD, 16'd0,    -16'sd1383,   16'sd32767, 16'sd0,    1'b1, 10'sd90},
		'{1'b0, REG_SPAN_THRESHOLD, 16'd0,    -16'sd1383,  -16'sd32768, 16'sd0,    1'b1, 10'sd270},
		// Extreme corners, a diagonal and a unit vector, all left to the predictor.
		'{1'b0, REG_SPAN_THRESHOLD, 16'd0,     16'sd32767, -16'sd32768,-16'sd1,    1'b0, 10'sd0},
		'{1'b0, REG_SPAN_THRESHOLD, 16'd0,    -16'sd32768,  16'sd32767, 16'sd1,    1'b0, 10'sd0},
		'{1'b0, REG_SPAN_THRESHOLD, 16'd0,    -16'sd383,    16'sd17333, 16'sd0,    1'b0, 10'sd0},
		'{1'b0, REG_SPAN_THRESHOLD, 16'd0,    -16'sd1382,   16'sd16334, 16'sd0,    1'b0, 10'sd0},
		// Declination of +180. A sum of exactly 360 is kept, and one above it wraps.
		'{1'b1, REG_DECLINATION,    16'd180,   16'sd30000,  16'sd16333, 16'sd0,    1'b1, 10'sd180},
		'{1'b0, REG_SPAN_THRESHOLD, 16'd0,    -16'sd32768,  16'sd16333, 16'sd0,    1'b1, 10'sd360},
		'{1'b0, REG_SPAN_THRESHOLD, 16'd0,    -16'sd1383,  -16'sd32768, 16'sd0,    1'b1, 10'sd90},
		// Declination of -180, written sign-extended to the full data width. Negative sums pass through.
		'{1'b1, REG_DECLINATION,    16'hFF4C,  16'sd30000,  16'sd16333, 16'sd0,    1'b1, -10'sd180}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	chc_sample_if smp ();
	chc_result_if rslt ();

	compass_heading_hard_iron_cal_core #(
		.CAL_SAMPLES  (CAL_SAMPLES),
		.CORDIC_STEPS (CORDIC_ITERS)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (smp),
		.result    (rslt),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Predictor state: the calibration progress, the running extremes per axis,
	// the applied offsets and the two registers.
	logic                  cal_done;
	logic [10:0]           cal_seen;
	int                    axis_hi [3];
	int                    axis_lo [3];
	int                    iron_ofs [3];
	logic [CFG_DATA_W-1:0] span_min;
	int                    decl_now;

	// Results still owed by the core, oldest first.
	reading_t readings_due [$];

	int  err_count;
	bit  snd_idle;
	bit  rcv_idle;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Idle stretch length. Most are short, and a few are long.
	function automatic int gap_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Saturate an offset-relative coordinate back into the sample range.
	function automatic logic signed [SMP_W-1:0] to_smp(input int v);
		if (v > 32767)
			return 16'sh7FFF;
		if (v < -32768)
			return 16'sh8000;
		return SMP_W'(v);
	endfunction

	// Vector angle in 1/65536 degree, in [0, 360). The vector is first folded into the
	// right half plane, then rotated towards the x axis. Each step adds or subtracts
	// the rotation angle, so the sum of those angles tracks the original angle.
	function automatic longint fine_bearing(input longint vx, input longint vy);
		longint ax;
		longint ay;
		longint ang;
		longint tx;
		longint ty;
		if (vx == 0 && vy == 0)
			return 0;
		if (vy == 0)
			return (vx > 0) ? 0 : 180 * DEG_UNIT;
		if (vx == 0)
			return (vy > 0) ? 90 * DEG_UNIT : 270 * DEG_UNIT;
		ax = vx;
		ay = vy;
		ang = 0;
		if (ax < 0) begin
			ax = -ax;
			ay = -ay;
			ang = 180 * DEG_UNIT;
		end
		for (int i = 0; i < CORDIC_ITERS; i++) begin
			tx = ax >>> i;
			ty = ay >>> i;
			if (ay >= 0) begin
				ax = ax + ty;
				ay = ay - tx;
				ang = ang + ATAN_STEP[i];
			end else begin
				ax = ax - ty;
				ay = ay + tx;
				ang = ang - ATAN_STEP[i];
			end
		end
		while (ang < 0)
			ang = ang + 360 * DEG_UNIT;
		while (ang >= 360 * DEG_UNIT)
			ang = ang - 360 * DEG_UNIT;
		return ang;
	endfunction

	// Run one accepted sample through the predictor. If it produces a result,
	// queue the expected result. A typed row supplies its own expected heading.
	task automatic track_sample(input logic signed [SMP_W-1:0] sx, input logic signed [SMP_W-1:0] sy,
			input logic signed [SMP_W-1:0] sz, input logic typed,
			input logic signed [HEAD_W-1:0] typed_hdg);
		int       v [3];
		longint   deg;
		int       hsum;
		reading_t r;
		v[0] = sx;
		v[1] = sy;
		v[2] = sz;
		if (!cal_done) begin
			for (int a = 0; a < 3; a++) begin
				if (cal_seen == 0) begin
					axis_hi[a] = v[a];
					axis_lo[a] = v[a];
				end else begin
					if (v[a] > axis_hi[a])
						axis_hi[a] = v[a];
					if (v[a] < axis_lo[a])
						axis_lo[a] = v[a];
				end
			end
			cal_seen = cal_seen + 11'd1;
			if (cal_seen < CAL_SAMPLES)
				return;
			// Only axes that swung far enough get an offset. The division truncates toward zero.
			for (int a = 0; a < 3; a++)
				if (axis_hi[a] - axis_lo[a] > int'(span_min))
					iron_ofs[a] = (axis_hi[a] + axis_lo[a]) / 2;
			cal_done = 1'b1;
			r = '{KIND_REPORT, '0, SMP_W'(iron_ofs[0]), SMP_W'(iron_ofs[1]), SMP_W'(iron_ofs[2])};
		end else begin
			deg = fine_bearing(longint'(v[0] - iron_ofs[0]), longint'(v[1] - iron_ofs[1])) / DEG_UNIT;
			hsum = int'(deg) + decl_now;
			if (hsum > 360)
				hsum = hsum - 360;
			r = '{KIND_HEADING, HEAD_W'(hsum), SMP_W'(iron_ofs[0]), SMP_W'(iron_ofs[1]),
				SMP_W'(iron_ofs[2])};
		end
		if (typed)
			r = '{KIND_HEADING, typed_hdg, CAL_OFS_X, CAL_OFS_Y, CAL_OFS_Z};
		readings_due.push_back(r);
	endtask

	// Register write. Called at a falling edge, and it returns at one.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_SPAN_THRESHOLD: span_min = val;
			REG_DECLINATION:    decl_now = int'($signed(val[DECL_W-1:0]));
			default: ;
		endcase
	endtask

	// Hold the sender back until every owed result has arrived. Then give the core
	// time to finish anything that produces no result.
	task automatic drain();
		smp.valid = 1'b0;
		while (readings_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Offer one sample and wait for its transfer. valid stays high between
	// back-to-back samples and drops only for a real gap.
	task automatic send_sample(input logic signed [SMP_W-1:0] sx, input logic signed [SMP_W-1:0] sy,
			input logic signed [SMP_W-1:0] sz, input logic typed,
			input logic signed [HEAD_W-1:0] typed_hdg);
		int gap;
		gap = (snd_idle && $urandom_range(0, 99) < 40) ? gap_len() : 0;
		if (gap > 0) begin
			smp.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		smp.valid = 1'b1;
		smp.mag_x = sx;
		smp.mag_y = sy;
		smp.mag_z = sz;
		do
			@(posedge clk);
		while (!smp.ready);
		track_sample(sx, sy, sz, typed, typed_hdg);
		@(negedge clk);
	endtask

	// Stimulus: reset, the directed table, then six phases of random headings, each
	// under the register settings and idle pattern set at its start.
	initial begin : stimulus
		logic signed [SMP_W-1:0] rx;
		logic signed [SMP_W-1:0] ry;
		logic signed [SMP_W-1:0] rz;
		int                      mode;
		int                      k;
		dir_row_t                row;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_SPAN_THRESHOLD;
		cfg_data = '0;
		smp.valid = 1'b0;
		smp.mag_x = '0;
		smp.mag_y = '0;
		smp.mag_z = '0;
		cal_done = 1'b0;
		cal_seen = '0;
		span_min = '0;
		decl_now = 0;
		err_count = 0;
		snd_idle = 1'b1;
		rcv_idle = 1'b1;
		for (int a = 0; a < 3; a++) begin
			axis_hi[a] = 0;
			axis_lo[a] = 0;
			iron_ofs[a] = 0;
		end
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Start calibration with the largest threshold, then lower it partway through.
		write_reg(REG_SPAN_THRESHOLD, 16'hFFFF);
		write_reg(REG_DECLINATION, 16'd0);

		for (int n = 0; n < DIR_ROWS; n++) begin
			row = dir_table[n];
			if (row.wr) begin
				drain();
				write_reg(row.reg_idx, row.reg_val);
			end
			send_sample(row.x, row.y, row.z, row.typed, row.hdg);
		end

		for (int ph = 0; ph < 6; ph++) begin
			// Each drain here also checks that the sender can hold off while the
			// core empties completely.
			drain();
			case (ph)
				0: begin
					write_reg(REG_SPAN_THRESHOLD, 16'h0000);
					write_reg(REG_DECLINATION, 16'd255);
					snd_idle = 1'b1;
					rcv_idle = 1'b1;
				end
				1: begin
					write_reg(REG_SPAN_THRESHOLD, 16'hFFFF);
					write_reg(REG_DECLINATION, 16'h0100);
					snd_idle = 1'b0;
					rcv_idle = 1'b0;
				end
				2: begin
					write_reg(REG_SPAN_THRESHOLD, 16'($urandom()));
					write_reg(REG_DECLINATION, 16'd180);
					snd_idle = 1'b1;
					rcv_idle = 1'b0;
				end
				3: begin
					write_reg(REG_DECLINATION, 16'(-180));
					snd_idle = 1'b0;
					rcv_idle = 1'b1;
				end
				4: begin
					write_reg(REG_DECLINATION, 16'($urandom()));
					snd_idle = 1'b1;
					rcv_idle = 1'b1;
				end
				default: begin
					write_reg(REG_SPAN_THRESHOLD, 16'($urandom()));
					write_reg(REG_DECLINATION, 16'd0);
					snd_idle = 1'b1;
					rcv_idle = 1'b1;
				end
			endcase

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				mode = $urandom_range(0, 9);
				rz = 16'($urandom());
				case (mode)
					0, 1, 2, 3, 4: begin
						rx = 16'($urandom());
						ry = 16'($urandom());
					end
					5, 6: begin
						// Moderate vectors around the corrected origin.
						rx = to_smp(iron_ofs[0] + int'($urandom_range(0, 4000)) - 2000);
						ry = to_smp(iron_ofs[1] + int'($urandom_range(0, 4000)) - 2000);
					end
					7: begin
						// Exactly on an axis after correction.
						if ($urandom_range(0, 1)) begin
							rx = to_smp(iron_ofs[0]);
							ry = 16'($urandom());
						end else begin
							rx = 16'($urandom());
							ry = to_smp(iron_ofs[1]);
						end
					end
					8: begin
						// Tiny vectors, the zero vector among them.
						rx = to_smp(iron_ofs[0] + int'($urandom_range(0, 6)) - 3);
						ry = to_smp(iron_ofs[1] + int'($urandom_range(0, 6)) - 3);
					end
					default: begin
						// Diagonals, where the quadrant borders and rounding meet.
						k = $urandom_range(1, 15000);
						rx = to_smp(iron_ofs[0] + ($urandom_range(0, 1) ? k : -k));
						ry = to_smp(iron_ofs[1] + ($urandom_range(0, 1) ? k : -k));
					end
				endcase
				send_sample(rx, ry, rz, 1'b0, '0);
			end
		end

		smp.valid = 1'b0;
		while (readings_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("[compass_heading_hard_iron_cal_core] OK");
		else
			$display("[compass_heading_hard_iron_cal_core] ERROR");
		$finish;
	end

	// Result side. ready drops for random stretches when idling is enabled.
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		rslt.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				rslt.ready = 1'b0;
				stall_left--;
			end else if (rcv_idle && $urandom_range(0, 99) < 15) begin
				stall_left = gap_len() - 1;
				rslt.ready = 1'b0;
			end else begin
				rslt.ready = 1'b1;
			end
		end
	end

	// Compare every result transfer with the oldest owed result, one field at a time.
	always @(posedge clk) begin : result_check
		reading_t want;
		if (arst_n && rslt.valid && rslt.ready) begin
			if (readings_due.size() == 0) begin
				$error("result with nothing owed: kind %0d heading %0d", rslt.result_kind,
					rslt.heading_deg);
				err_count++;
			end else begin
				want = readings_due.pop_front();
				if (rslt.result_kind !== want.kind) begin
					$error("result_kind: expected %0d, got %0d", want.kind, rslt.result_kind);
					err_count++;
				end
				if (rslt.heading_deg !== want.hdg) begin
					$error("heading_deg: expected %0d, got %0d", want.hdg, rslt.heading_deg);
					err_count++;
				end
				if (rslt.offset_x_out !== want.ofs_x) begin
					$error("offset_x_out: expected %0d, got %0d", want.ofs_x, rslt.offset_x_out);
					err_count++;
				end
				if (rslt.offset_y_out !== want.ofs_y) begin
					$error("offset_y_out: expected %0d, got %0d", want.ofs_y, rslt.offset_y_out);
					err_count++;
				end
				if (rslt.offset_z_out !== want.ofs_z) begin
					$error("offset_z_out: expected %0d, got %0d", want.ofs_z, rslt.offset_z_out);
					err_count++;
				end
			end
		end
	end

	// Watchdog for a core that stops making progress.
	initial begin : watchdog
		int cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("[compass_heading_hard_iron_cal_core] ERROR");
				$finish;
			end
		end
	end

endmodule

@@ compass_heading_hard_iron_cal_core.f @@
rtl/chc_pkg.sv
rtl/chc_ifs.sv
rtl/chc_queue.sv
rtl/chc_front.sv
rtl/chc_back.sv
rtl/compass_heading_hard_iron_cal_core.sv
test/testbench.sv
